FILE: hdl/utf8_byte_stream_decoder_macros.svh
// assertion macros for the utf8 byte stream decoder
`ifndef UTF8_BYTE_STREAM_DECODER_MACROS_SVH
`define UTF8_BYTE_STREAM_DECODER_MACROS_SVH

// condition holds at every edge outside reset
`define U8BSD_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define U8BSD_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define U8BSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hdl/u8bsd_pkg.sv
// constants for the utf8 byte stream decoder
package u8bsd_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 26;
  localparam int LEN_W  = 3;
  localparam int CONT_W = 6;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CP_W-1:0]   cp_t;
  typedef logic [LEN_W-1:0]  len_t;

  localparam cp_t REPLACEMENT_CHAR = CP_W'(32'h0000_FFFD);

  localparam len_t LEN_NONE = 3'd0;
  localparam len_t LEN_1    = 3'd1;
  localparam len_t LEN_2    = 3'd2;
  localparam len_t LEN_3    = 3'd3;
  localparam len_t LEN_4    = 3'd4;
  localparam len_t LEN_5    = 3'd5;

  // lead byte prefixes
  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [4:0] LEAD4_TAG = 5'b11110;
  localparam logic [5:0] LEAD5_TAG = 6'b111110;

endpackage

FILE: hdl/utf8_byte_stream_decoder.sv
// top level of the utf8 byte stream decoder
// Decodes a UTF-8 byte stream, one byte per transaction, into codepoints.
// A byte below 0x80 gives its own value at once; a continuation byte with no
// sequence open gives 0xFFFD with stray set; lead bytes open sequences of two
// to five bytes whose following bytes are taken unchecked, six bits each, and
// the codepoint appears with the last byte; 0xFC-0xFF give the byte's low six
// bits as a one-byte codepoint. A byte that does not close a sequence gives
// no result. Rate: one byte per clock cycle while out_stall is low. Each
// accepted byte is classified and shifted into the accumulator, and any
// result lands in the output register on the same edge. The only thing that
// holds input back is a result waiting in the output register while the
// downstream side stalls: in_stall follows that condition combinationally.
module utf8_byte_stream_decoder (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  u8bsd_pkg::byte_t  byte_in,
  output logic              out_valid,
  input  logic              out_stall,
  output u8bsd_pkg::cp_t    codepoint,
  output u8bsd_pkg::len_t   seq_length,
  output logic              stray
);
  import u8bsd_pkg::*;

  `include "utf8_byte_stream_decoder_macros.svh"

  // decoder state
  len_t remaining;
  len_t total_len;
  cp_t  accum;

  len_t remaining_next;
  len_t total_len_next;
  cp_t  accum_next;

  // result of the current byte
  logic emit;
  cp_t  cp_res;
  len_t len_res;
  logic stray_res;

  logic in_fire;

  // hold the input while a result sits unread in the output register
  assign in_stall = out_valid & out_stall;
  assign in_fire  = in_valid & ~in_stall;

  always_comb begin
    remaining_next = remaining;
    total_len_next = total_len;
    accum_next     = accum;
    emit           = 1'b0;
    cp_res         = {{(CP_W-BYTE_W){1'b0}}, byte_in};
    len_res        = LEN_1;
    stray_res      = 1'b0;

    if (remaining != LEN_NONE) begin
      // inside a sequence: any byte counts as a continuation
      accum_next     = {accum[CP_W-CONT_W-1:0], byte_in[CONT_W-1:0]};
      remaining_next = remaining - LEN_1;
      emit           = (remaining == LEN_1);
      cp_res         = accum_next;
      len_res        = total_len;
    end else if (!byte_in[7]) begin
      // plain ascii
      emit = 1'b1;
    end else if (!byte_in[6]) begin
      // continuation byte with nothing open
      emit      = 1'b1;
      cp_res    = REPLACEMENT_CHAR;
      stray_res = 1'b1;
    end else if (byte_in[7:5] == LEAD2_TAG) begin
      accum_next     = {{(CP_W-5){1'b0}}, byte_in[4:0]};
      total_len_next = LEN_2;
      remaining_next = LEN_1;
    end else if (byte_in[7:4] == LEAD3_TAG) begin
      accum_next     = {{(CP_W-4){1'b0}}, byte_in[3:0]};
      total_len_next = LEN_3;
      remaining_next = LEN_2;
    end else if (byte_in[7:3] == LEAD4_TAG) begin
      accum_next     = {{(CP_W-3){1'b0}}, byte_in[2:0]};
      total_len_next = LEN_4;
      remaining_next = LEN_3;
    end else if (byte_in[7:2] == LEAD5_TAG) begin
      accum_next     = {{(CP_W-2){1'b0}}, byte_in[1:0]};
      total_len_next = LEN_5;
      remaining_next = LEN_4;
    end else begin
      // 0xfc-0xff: single byte, low six bits only
      emit   = 1'b1;
      cp_res = {{(CP_W-CONT_W){1'b0}}, byte_in[CONT_W-1:0]};
    end
  end

  // state update on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= LEN_NONE;
      total_len <= LEN_NONE;
      accum     <= '0;
    end else if (in_fire) begin
      remaining <= remaining_next;
      total_len <= total_len_next;
      accum     <= accum_next;
    end
  end

  // output register: refilled or emptied whenever it is not held
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_fire & emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      codepoint  <= cp_res;
      seq_length <= len_res;
      stray      <= stray_res;
    end
  end

  // checks on the decoder's own bookkeeping
  `U8BSD_ASSERT_ALWAYS(a_remaining_range, remaining <= LEN_4)
  `U8BSD_ASSERT_IMPLIES(a_open_shorter, remaining != LEN_NONE, remaining < total_len)
  `U8BSD_ASSERT_IMPLIES(a_stray_result, out_valid && stray,
    codepoint == REPLACEMENT_CHAR && seq_length == LEN_1)
  `U8BSD_ASSERT_NEXT(a_last_byte_emits, in_fire && remaining == LEN_1,
    out_valid && seq_length == $past(total_len))

endmodule

FILE: tb/sv/tb_top.sv
// self-checking testbench for the utf8 byte stream decoder
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import u8bsd_pkg::*;

  // random part length, receiver hold-off point and length, run limit
  localparam int RAND_ITEMS  = 400;
  localparam int HOLD_AT     = 340;
  localparam int HOLD_CYCLES = 60;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 8;

  // idling phases: sender/receiver idle percentages per phase
  localparam logic [1:0] PH_TX_LIGHT = 2'd0;  // sender 22, receiver 61
  localparam logic [1:0] PH_TX_HEAVY = 2'd1;  // sender 61, receiver 22
  localparam logic [1:0] PH_NO_IDLE  = 2'd2;  // neither idles

  // one pending input transaction and the phase it belongs to
  typedef struct {
    byte_t      value;
    logic [1:0] phase;
    logic       drain;  // hold back until every expected codepoint has come
  } byte_item_t;

  // one expected output transaction
  typedef struct {
    cp_t  cp;
    len_t len;
    logic stray;
  } cp_result_t;

  logic  clk        = 1'b0;
  logic  rst        = 1'b1;
  logic  in_valid   = 1'b0;
  logic  in_stall;
  byte_t byte_in    = '0;
  logic  out_valid;
  logic  out_stall  = 1'b0;
  cp_t   codepoint;
  len_t  seq_length;
  logic  stray;

  byte_item_t byte_q[$];       // bytes still to be offered
  cp_result_t cp_expect_q[$];  // codepoints predicted, not yet seen

  // decoder state as predicted
  logic [2:0] dec_remaining = '0;
  cp_t        dec_accum     = '0;
  len_t       dec_total     = LEN_NONE;

  logic [1:0] rx_phase  = PH_TX_LIGHT;
  logic       hold_off  = 1'b0;
  int         sent_cnt  = 0;
  int         err_cnt   = 0;
  int         cycle_cnt = 0;

  utf8_byte_stream_decoder dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .byte_in    (byte_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .codepoint  (codepoint),
    .seq_length (seq_length),
    .stray      (stray)
  );

  always #4 clk = ~clk;

  task automatic queue_byte(byte_t v, logic [1:0] ph, logic drain);
    byte_item_t it;
    it.value = v;
    it.phase = ph;
    it.drain = drain;
    byte_q.push_back(it);
  endtask

  function automatic void push_codepoint(cp_t cp, len_t len, logic is_stray);
    cp_result_t r;
    r.cp    = cp;
    r.len   = len;
    r.stray = is_stray;
    cp_expect_q.push_back(r);
  endfunction

  // advance the predicted decoder by one accepted byte
  function automatic void decode_byte(byte_t b);
    if (dec_remaining != 3'd0) begin
      // inside a sequence every byte counts as a continuation, unchecked
      dec_accum     = {dec_accum[CP_W-CONT_W-1:0], b[CONT_W-1:0]};
      dec_remaining = dec_remaining - 3'd1;
      if (dec_remaining == 3'd0) begin
        push_codepoint(dec_accum, dec_total, 1'b0);
      end
    end else if (!b[7]) begin
      push_codepoint(cp_t'(b), LEN_1, 1'b0);
    end else if (b[7:6] == 2'b10) begin
      // lone continuation byte
      push_codepoint(REPLACEMENT_CHAR, LEN_1, 1'b1);
    end else if (b[7:5] == LEAD2_TAG) begin
      dec_accum     = cp_t'(b[4:0]);
      dec_total     = LEN_2;
      dec_remaining = 3'd1;
    end else if (b[7:4] == LEAD3_TAG) begin
      dec_accum     = cp_t'(b[3:0]);
      dec_total     = LEN_3;
      dec_remaining = 3'd2;
    end else if (b[7:3] == LEAD4_TAG) begin
      dec_accum     = cp_t'(b[2:0]);
      dec_total     = LEN_4;
      dec_remaining = 3'd3;
    end else if (b[7:2] == LEAD5_TAG) begin
      dec_accum     = cp_t'(b[1:0]);
      dec_total     = LEN_5;
      dec_remaining = 3'd4;
    end else begin
      // 0xfc-0xff behave as a one-byte sequence of their low six bits
      push_codepoint(cp_t'(b[CONT_W-1:0]), LEN_1, 1'b0);
    end
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycle_cnt, what);
    err_cnt++;
  endtask

  // driver: offers the front of byte_q, predicts on every accepted transaction
  always @(posedge clk) begin : driver
    logic  nxt_valid;
    byte_t nxt_byte;
    int    idle_pct;
    nxt_valid = in_valid;
    nxt_byte  = byte_in;
    if (rst) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(byte_in);
        rx_phase <= byte_q[0].phase;
        void'(byte_q.pop_front());
        sent_cnt++;
        nxt_valid = 1'b0;
      end
      // a new offer only when nothing is held; a stalled byte stays put
      if (!nxt_valid && byte_q.size() != 0) begin
        idle_pct = (byte_q[0].phase == PH_TX_LIGHT) ? 22 :
                   (byte_q[0].phase == PH_TX_HEAVY) ? 61 : 0;
        if (byte_q[0].drain && cp_expect_q.size() != 0) begin
          nxt_valid = 1'b0;
        end else if ($urandom_range(0, 99) >= idle_pct) begin
          nxt_valid = 1'b1;
          nxt_byte  = byte_q[0].value;
        end
      end
    end
    in_valid <= nxt_valid;
    byte_in  <= nxt_byte;
  end

  // receiver stall: random per phase, forced high during the hold-off
  always @(posedge clk) begin : receiver
    int idle_pct;
    idle_pct = (rx_phase == PH_TX_LIGHT) ? 61 : (rx_phase == PH_TX_HEAVY) ? 22 : 0;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_off || ($urandom_range(0, 99) < idle_pct);
    end
  end

  // monitor: every accepted codepoint against the oldest prediction
  always @(posedge clk) begin : monitor
    cp_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (cp_expect_q.size() == 0) begin
        report_mismatch($sformatf("codepoint %h with nothing expected", codepoint));
      end else begin
        want = cp_expect_q.pop_front();
        if (codepoint !== want.cp) begin
          report_mismatch($sformatf("codepoint %h, expected %h", codepoint, want.cp));
        end
        if (seq_length !== want.len) begin
          report_mismatch($sformatf("seq_length %0d, expected %0d", seq_length, want.len));
        end
        if (stray !== want.stray) begin
          report_mismatch($sformatf("stray %b, expected %b", stray, want.stray));
        end
      end
    end
  end

  // long receiver hold-off while the sender keeps offering, so input backs up
  initial begin : hold_off_ctl
    while (sent_cnt < HOLD_AT) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL utf8_byte_stream_decoder");
      $finish;
    end
  end

  initial begin : main
    byte_t      dir_bytes[$];
    int         n;
    int         len;
    logic [1:0] ph;
    logic [1:0] last_ph;
    logic       drain;
    byte_t      lead;
    byte_t      b;

    // directed: ascii and stray continuation ends, lowest two-byte and highest
    // longer sequences, any byte inside a sequence, and the 0xfc-0xff group
    dir_bytes = '{8'h00, 8'h7F, 8'h80, 8'hBF,
                  8'hC0, 8'h80,
                  8'hEF, 8'hBF, 8'hBF,
                  8'hF7, 8'hBF, 8'hBF, 8'hBF,
                  8'hFB, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
                  8'hF8, 8'h7F, 8'hC0, 8'hFF, 8'h00,
                  8'hFC, 8'hFF};
    foreach (dir_bytes[i]) queue_byte(dir_bytes[i], PH_TX_LIGHT, 1'b0);

    // random: mostly well-formed sequences with random payload, some noise
    n       = 0;
    last_ph = PH_TX_LIGHT;
    while (n < RAND_ITEMS) begin
      ph      = 2'(n * 3 / RAND_ITEMS);
      drain   = (ph != last_ph) || ($urandom_range(0, 49) == 0);
      last_ph = ph;
      if ($urandom_range(0, 99) < 80) begin
        len = $urandom_range(1, 5);
        case (len)
          1: lead = byte_t'($urandom_range(0, 127));
          2: lead = {LEAD2_TAG, 5'($urandom)};
          3: lead = {LEAD3_TAG, 4'($urandom)};
          4: lead = {LEAD4_TAG, 3'($urandom)};
          default: lead = {LEAD5_TAG, 2'($urandom)};
        endcase
        queue_byte(lead, ph, drain);
        n++;
        for (int k = 1; k < len; k++) begin
          // now and then a non-continuation byte inside the sequence
          b = ($urandom_range(0, 7) == 0) ? byte_t'($urandom) : {2'b10, 6'($urandom)};
          queue_byte(b, ph, 1'b0);
          n++;
        end
      end else begin
        queue_byte(byte_t'($urandom), ph, drain);
        n++;
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (byte_q.size() != 0 || in_valid) @(posedge clk);
    while (cp_expect_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (cp_expect_q.size() != 0) begin
      report_mismatch($sformatf("%0d codepoints never arrived", cp_expect_q.size()));
    end
    if (err_cnt == 0) begin
      $display("PASS utf8_byte_stream_decoder");
    end else begin
      $display("FAIL utf8_byte_stream_decoder");
    end
    $finish;
  end

endmodule
